>>> sv/gmpw_pkg.sv
// shared widths, limits and register codes for the grid maximum path block
package gmpw_pkg;

    // field widths
    localparam int VAL_W     = 11;
    localparam int SUM_W     = 22;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;

    // default grid limits
    localparam int MAX_ROWS_DEF = 1024;
    localparam int MAX_COLS_DEF = 1024;

    // configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_ROWS  = 3'd0,
        REG_GRID_COLS  = 3'd1,
        REG_WALL_ROW_A = 3'd2,
        REG_WALL_COL_A = 3'd3,
        REG_WALL_ROW_B = 3'd4,
        REG_WALL_COL_B = 3'd5
    } t_cfg_reg;

endpackage

>>> sv/gmpw_in_if.sv
// input channel: one grid cell value per word
interface gmpw_in_if;
    import gmpw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

>>> sv/gmpw_out_if.sv
// output channel: best path sum and reach flag per grid
interface gmpw_out_if;
    import gmpw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] best_sum;
    logic                    reachable;

    modport source (output valid, output best_sum, output reachable, input ready);
    modport sink   (input valid, input best_sum, input reachable, output ready);
endinterface

>>> sv/gmpw_ram.sv
// generic single write port ram with registered read
module gmpw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/grid_max_path_with_wall.sv
// top level: streaming maximum right/down path sum over a grid with one wall
//
// Cells enter on i_cell in row-major order, one word per cell, for a grid of
// grid_rows by grid_cols cells set through the write port (i_cfg_we,
// i_cfg_idx, i_cfg_wdata). Registers 2..5 place one straight wall on the grid
// lines; horizontal when both rows match, vertical otherwise. After the last
// cell of a grid one word leaves on o_res: best_sum (saturated) and
// reachable; best_sum is zero when the corner cannot be reached.
// Throughput is one cell per cycle, set by the single ram read port and the
// left-sum loop, unless a blocked result word holds the compute stage. The
// row buffer entry above a cell is read from a one-read one-write ram at the
// edge the cell is taken, and the max and add happen in the following cycle;
// the result word is registered as the last cell of a grid leaves that stage.
// Reset clears position to the top-left cell, the configuration to a 1 by 1
// grid with no wall, and empties the pipeline; the row buffer is not cleared,
// each row overwrites what the next row reads.
// When the receiver stalls, the result word holds and cells keep flowing
// until a second last cell reaches the compute stage; then i_cell.ready drops.
module grid_max_path_with_wall #(
    parameter int MAX_ROWS = gmpw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gmpw_pkg::MAX_COLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    gmpw_in_if.sink                        i_cell,
    gmpw_out_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [gmpw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [gmpw_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import gmpw_pkg::*;

    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int CW  = $clog2(MAX_COLS + 1);
    localparam int AW  = $clog2(MAX_COLS);
    localparam int KW0 = (RW > CW) ? RW : CW;
    localparam int KW  = (KW0 > CFG_W + 1) ? KW0 : CFG_W + 1;
    localparam int DW  = SUM_W + 1;

    typedef struct packed {
        logic signed [VAL_W-1:0] val;
        logic                    first;
        logic                    gate_up;
        logic                    gate_left;
        logic [AW-1:0]           addr;
        logic                    eor;
        logic                    last;
    } t_s1;

    // configuration registers
    logic [CFG_W-1:0] r_grid_rows, r_grid_cols;
    logic [CFG_W-1:0] r_wall_row_a, r_wall_col_a, r_wall_row_b, r_wall_col_b;

    // position of the next cell
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;

    // compute stage
    logic            r_s1_vld;
    t_s1             r_s1, n_s1;
    logic            s1_fire;
    logic            r_fwd;
    logic [DW-1:0]   r_fwd_data;

    // left neighbor
    logic signed [SUM_W-1:0] r_left_sum;
    logic                    r_left_reach;

    // output register
    logic                    r_out_vld;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                    r_out_reach;

    logic accept;

    // size clamp and wall ordering
    logic [KW-1:0] rows_k, cols_k, row_k, col_k;
    logic [KW-1:0] wr_a, wr_b, wc_a, wc_b, r_lo, r_hi, c_lo, c_hi;
    logic          horiz, block_up, block_left, col_end, row_end;
    logic [CW-1:0] col_m1;

    always_comb begin
        rows_k = KW'(r_grid_rows);
        if (rows_k == '0) begin
            rows_k = KW'(1);
        end else if (rows_k > KW'(MAX_ROWS)) begin
            rows_k = KW'(MAX_ROWS);
        end
        cols_k = KW'(r_grid_cols);
        if (cols_k == '0) begin
            cols_k = KW'(1);
        end else if (cols_k > KW'(MAX_COLS)) begin
            cols_k = KW'(MAX_COLS);
        end
        wr_a  = KW'(r_wall_row_a);
        wr_b  = KW'(r_wall_row_b);
        wc_a  = KW'(r_wall_col_a);
        wc_b  = KW'(r_wall_col_b);
        r_lo  = (wr_a > wr_b) ? wr_b : wr_a;
        r_hi  = (wr_a > wr_b) ? wr_a : wr_b;
        c_lo  = (wc_a > wc_b) ? wc_b : wc_a;
        c_hi  = (wc_a > wc_b) ? wc_a : wc_b;
        horiz = (r_lo == r_hi);
        row_k = KW'(r_row);
        col_k = KW'(r_col);
        block_up   = horiz && (c_lo < col_k) && (col_k <= c_hi) &&
                     (row_k == r_lo + KW'(1));
        block_left = !horiz && (r_lo < row_k) && (row_k <= r_hi) &&
                     (col_k == c_lo + KW'(1));
        col_end = (col_k >= cols_k);
        row_end = (row_k >= rows_k);
        col_m1  = r_col - CW'(1);
    end

    // decode of the cell being taken
    always_comb begin
        n_s1.val       = i_cell.cell_value;
        n_s1.first     = (r_row == RW'(1)) && (r_col == CW'(1));
        n_s1.gate_up   = (r_row != RW'(1)) && !block_up;
        n_s1.gate_left = (r_col != CW'(1)) && !block_left;
        n_s1.addr      = col_m1[AW-1:0];
        n_s1.eor       = col_end;
        n_s1.last      = col_end && row_end;
    end

    // next position
    always_comb begin
        n_row = r_row;
        n_col = r_col + CW'(1);
        if (col_end) begin
            n_col = CW'(1);
            n_row = row_end ? RW'(1) : r_row + RW'(1);
        end
    end

    assign s1_fire      = r_s1_vld && (!r_s1.last || !r_out_vld || o_res.ready);
    assign i_cell.ready = !r_s1_vld || s1_fire;
    assign accept       = i_cell.valid && i_cell.ready;

    // row buffer: sum and reach bit of the row above
    logic [DW-1:0] ram_rdata, wr_data;

    gmpw_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_COLS)
    ) u_row_buf (
        .i_clk   (i_clk),
        .i_we    (s1_fire),
        .i_waddr (r_s1.addr),
        .i_wdata (wr_data),
        .i_re    (accept),
        .i_raddr (n_s1.addr),
        .o_rdata (ram_rdata)
    );

    // cell sum: max of allowed neighbors plus value, saturated
    logic [DW-1:0]           above;
    logic signed [SUM_W-1:0] up_sum, pick, sum;
    logic signed [SUM_W:0]   wide;
    logic                    up_ok, left_ok, reach;

    always_comb begin
        above   = r_fwd ? r_fwd_data : ram_rdata;
        up_sum  = above[SUM_W-1:0];
        up_ok   = r_s1.gate_up && above[SUM_W];
        left_ok = r_s1.gate_left && r_left_reach;
        pick    = up_sum;
        if (up_ok && left_ok) begin
            pick = (up_sum > r_left_sum) ? up_sum : r_left_sum;
        end else if (left_ok) begin
            pick = r_left_sum;
        end
        wide = {pick[SUM_W-1], pick} +
               {{(SUM_W + 1 - VAL_W){r_s1.val[VAL_W-1]}}, r_s1.val};
        if (wide[SUM_W] != wide[SUM_W-1]) begin
            sum = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum = wide[SUM_W-1:0];
        end
        reach = 1'b1;
        if (r_s1.first) begin
            sum = SUM_W'(r_s1.val);
        end else if (!up_ok && !left_ok) begin
            sum   = '0;
            reach = 1'b0;
        end
        wr_data = {reach, sum};
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows  <= CFG_W'(1);
            r_grid_cols  <= CFG_W'(1);
            r_wall_row_a <= '0;
            r_wall_col_a <= '0;
            r_wall_row_b <= '0;
            r_wall_col_b <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_GRID_ROWS:  r_grid_rows  <= i_cfg_wdata;
                REG_GRID_COLS:  r_grid_cols  <= i_cfg_wdata;
                REG_WALL_ROW_A: r_wall_row_a <= i_cfg_wdata;
                REG_WALL_COL_A: r_wall_col_a <= i_cfg_wdata;
                REG_WALL_ROW_B: r_wall_row_b <= i_cfg_wdata;
                REG_WALL_COL_B: r_wall_col_b <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // position, compute stage and left neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row        <= RW'(1);
            r_col        <= CW'(1);
            r_s1_vld     <= 1'b0;
            r_fwd        <= 1'b0;
            r_left_sum   <= '0;
            r_left_reach <= 1'b0;
        end else begin
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
                r_s1  <= n_s1;
                // same entry written this edge: take it from the write side
                r_fwd      <= s1_fire && (r_s1.addr == n_s1.addr);
                r_fwd_data <= wr_data;
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
                r_fwd    <= 1'b0;
            end
            if (s1_fire) begin
                r_left_sum   <= r_s1.eor ? '0 : sum;
                r_left_reach <= !r_s1.eor && reach;
            end
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (s1_fire && r_s1.last) begin
                r_out_vld   <= 1'b1;
                r_out_sum   <= sum;
                r_out_reach <= reach;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.best_sum  = r_out_sum;
    assign o_res.reachable = r_out_reach;

    // compute stage waits only behind a full result register
    a_s1_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_fire) |-> (r_s1.last && r_out_vld && !o_res.ready))
        else $error("compute stage stalled without a blocked result");

    // the last cell of a grid returns the position to the top-left cell
    a_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_s1.last) |=> (r_row == RW'(1) && r_col == CW'(1)))
        else $error("position did not wrap after the last cell");

    // forwarding only ever serves a cell held in the compute stage
    a_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_vld)
        else $error("forward flag set with empty compute stage");

    // a result is loaded only from a last cell
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_out_vld)) |-> $past(s1_fire && r_s1.last))
        else $error("result word appeared without a last cell");

endmodule

>>> bench/tb_top.sv
// testbench for the grid maximum path block: predicts each corner sum and checks every result word
module tb_top;
    import gmpw_pkg::*;

    localparam int CYCLE_LIMIT = 600_000;
    localparam int SUM_MAX     = 2 ** (SUM_W - 1) - 1;
    localparam int SUM_MIN     = -(2 ** (SUM_W - 1));

    typedef struct {
        logic signed [SUM_W-1:0] best_sum;
        logic                    reachable;
    } t_corner_result;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    gmpw_in_if  cell_if ();
    gmpw_out_if res_if ();

    grid_max_path_with_wall dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cell      (cell_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // idling mix of the current phase, in percent
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // run bookkeeping
    int cycle_count   = 0;
    int error_count   = 0;
    int cells_sent    = 0;
    int grids_checked = 0;
    int grids_blocked = 0;
    int reg_writes    = 0;

    // predictor copy of the registers
    logic [CFG_W-1:0] rows_cfg = 11'd1;
    logic [CFG_W-1:0] cols_cfg = 11'd1;
    logic [CFG_W-1:0] wall_ra  = '0;
    logic [CFG_W-1:0] wall_ca  = '0;
    logic [CFG_W-1:0] wall_rb  = '0;
    logic [CFG_W-1:0] wall_cb  = '0;

    // predictor copy of the row buffer and running position
    logic signed [SUM_W-1:0] sum_above [MAX_COLS_DEF];
    bit                      reach_above [MAX_COLS_DEF];
    logic signed [SUM_W-1:0] sum_left   = '0;
    bit                      reach_left = 1'b0;
    int                      row_pos    = 1;
    int                      col_pos    = 1;

    // corner results still owed by the block, oldest first
    t_corner_result corner_sums_due [$];

    // clock
    always #10 clk = ~clk;

    // cycle limit
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, corner_sums_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void report_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("mismatch: %s", msg);
    endfunction

    // result checker
    always @(posedge clk) begin
        t_corner_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (corner_sums_due.size() == 0) begin
                report_error($sformatf("unexpected word: sum %0d reachable %0b",
                                       res_if.best_sum, res_if.reachable));
            end else begin
                want = corner_sums_due.pop_front();
                grids_checked++;
                if (!want.reachable) grids_blocked++;
                if (res_if.best_sum !== want.best_sum)
                    report_error($sformatf("grid %0d best_sum: expected %0d, got %0d",
                                           grids_checked, want.best_sum, res_if.best_sum));
                if (res_if.reachable !== want.reachable)
                    report_error($sformatf("grid %0d reachable: expected %0b, got %0b",
                                           grids_checked, want.reachable, res_if.reachable));
            end
        end
    end

    function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : int'(v);
    endfunction

    function automatic int sat_sum(input int s);
        if (s > SUM_MAX) return SUM_MAX;
        if (s < SUM_MIN) return SUM_MIN;
        return s;
    endfunction

    // one cell through the path predictor; queues a corner result at grid end
    task automatic advance_path_sums(input logic signed [VAL_W-1:0] cell_value);
        int             rows_used, cols_used, slot;
        int             r_lo, r_hi, c_lo, c_hi, above, total;
        bit             flat_wall, via_up, via_left, reached;
        t_corner_result res;
        rows_used = clamp_size(rows_cfg, MAX_ROWS_DEF);
        cols_used = clamp_size(cols_cfg, MAX_COLS_DEF);
        slot      = col_pos - 1;
        r_lo      = (wall_ra < wall_rb) ? wall_ra : wall_rb;
        r_hi      = (wall_ra < wall_rb) ? wall_rb : wall_ra;
        c_lo      = (wall_ca < wall_cb) ? wall_ca : wall_cb;
        c_hi      = (wall_ca < wall_cb) ? wall_cb : wall_ca;
        flat_wall = (r_lo == r_hi);
        via_up    = (row_pos > 1) && reach_above[slot];
        via_left  = (col_pos > 1) && reach_left;
        above     = sum_above[slot];

        // horizontal wall blocks entry from above, vertical wall blocks entry from the left
        if (flat_wall && c_lo < col_pos && col_pos <= c_hi && row_pos == r_lo + 1)
            via_up = 1'b0;
        else if (!flat_wall && r_lo < row_pos && row_pos <= r_hi && col_pos == c_lo + 1)
            via_left = 1'b0;

        reached = 1'b1;
        total   = 0;
        if (row_pos == 1 && col_pos == 1)
            total = cell_value;
        else if (via_up && via_left)
            total = sat_sum(((above > sum_left) ? above : int'(sum_left)) + cell_value);
        else if (via_up)
            total = sat_sum(above + cell_value);
        else if (via_left)
            total = sat_sum(int'(sum_left) + cell_value);
        else
            reached = 1'b0;

        sum_above[slot]   = SUM_W'(total);
        reach_above[slot] = reached;
        sum_left          = SUM_W'(total);
        reach_left        = reached;

        // advance position, close row and grid
        if (col_pos >= cols_used) begin
            if (row_pos >= rows_used) begin
                res.best_sum  = SUM_W'(total);
                res.reachable = reached;
                corner_sums_due.push_back(res);
                row_pos = 1;
            end else begin
                row_pos++;
            end
            col_pos    = 1;
            sum_left   = '0;
            reach_left = 1'b0;
        end else begin
            col_pos++;
        end
    endtask

    // send one cell word, with random idle cycles ahead of it
    task automatic send_cell(input logic signed [VAL_W-1:0] cell_value);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            cell_if.valid <= 1'b0;
            @(negedge clk);
        end
        cell_if.valid      <= 1'b1;
        cell_if.cell_value <= cell_value;
        do @(posedge clk); while (!cell_if.ready);
        cells_sent++;
        advance_path_sums(cell_value);
    endtask

    // stop sending and wait for every owed result, then let the pipeline settle
    task automatic wait_results_in();
        @(negedge clk);
        cell_if.valid <= 1'b0;
        while (corner_sums_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input t_cfg_reg idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        reg_writes++;
        case (idx)
            REG_GRID_ROWS:  rows_cfg = val;
            REG_GRID_COLS:  cols_cfg = val;
            REG_WALL_ROW_A: wall_ra  = val;
            REG_WALL_COL_A: wall_ca  = val;
            REG_WALL_ROW_B: wall_rb  = val;
            REG_WALL_COL_B: wall_cb  = val;
            default: ;
        endcase
    endtask

    task automatic set_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
        set_reg(REG_GRID_ROWS, rows);
        set_reg(REG_GRID_COLS, cols);
    endtask

    task automatic set_wall(input logic [CFG_W-1:0] ra, input logic [CFG_W-1:0] ca,
                            input logic [CFG_W-1:0] rb, input logic [CFG_W-1:0] cb);
        set_reg(REG_WALL_ROW_A, ra);
        set_reg(REG_WALL_COL_A, ca);
        set_reg(REG_WALL_ROW_B, rb);
        set_reg(REG_WALL_COL_B, cb);
    endtask

    // mostly in the usual range, sometimes the full 11-bit span or its ends
    function automatic logic signed [VAL_W-1:0] rand_cell_value();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return -11'sd1024;
                    1: return 11'sd1023;
                    2: return -11'sd1000;
                    default: return 11'sd1000;
                endcase
            end
            1: return VAL_W'($urandom_range(2047));
            default: return VAL_W'(int'($urandom_range(2000)) - 1000);
        endcase
    endfunction

    task automatic send_grid(input int n);
        repeat (n) send_cell(rand_cell_value());
    endtask

    // single-cell grids at the value extremes and near zero, default size after reset
    task automatic test_corner_values();
        send_cell(11'sd1023);
        send_cell(-11'sd1024);
        send_cell(11'sd1000);
        send_cell(-11'sd1000);
        send_cell(11'sd0);
        send_cell(-11'sd1);
        wait_results_in();
    endtask

    // 2x2 grids: blocking walls, endpoint ordering, degenerate wall, forced path
    task automatic test_wall_shapes();
        set_size(11'd2, 11'd2);
        // horizontal wall under the whole first row
        set_wall(11'd1, 11'd0, 11'd1, 11'd2);
        send_grid(4);
        wait_results_in();
        // vertical wall right of column one, endpoints given high to low
        set_wall(11'd2, 11'd1, 11'd0, 11'd1);
        send_grid(4);
        wait_results_in();
        // point wall, no effect
        set_wall(11'd1, 11'd1, 11'd1, 11'd1);
        send_grid(4);
        wait_results_in();
        // corner forced to come from above through a poor cell
        set_wall(11'd1, 11'd1, 11'd2, 11'd1);
        send_cell(11'sd1);
        send_cell(-11'sd500);
        send_cell(11'sd800);
        send_cell(11'sd3);
        wait_results_in();
        // horizontal wall spanning past the last column line, to the register end
        set_wall(11'd1, 11'd2047, 11'd1, 11'd0);
        send_grid(4);
        wait_results_in();
    endtask

    // size zero, a column count past the limit, wall coordinates at the register ends
    task automatic test_size_limits();
        set_size(11'd0, 11'd0);
        send_grid(1);
        wait_results_in();
        set_wall(11'd0, 11'd2047, 11'd0, 11'd0);
        set_size(11'd1, 11'd2047);
        send_grid(MAX_COLS_DEF);
        wait_results_in();
    endtask

    // random small grids with random walls under one idling mix
    task automatic test_random_grids(input int idle_pct, input int stall_pct, input int quota);
        int               first, rows, cols, span, left, reps;
        logic [CFG_W-1:0] ra, ca, rb, cb;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        first          = cells_sent;
        while (cells_sent - first < quota) begin
            span = ($urandom_range(7) == 0) ? 16 : 10;
            rows = $urandom_range(span, 1);
            cols = $urandom_range(span, 1);
            // keep the phase close to its share of cells
            left = quota - (cells_sent - first);
            if (rows * cols > left) rows = (left + cols - 1) / cols;
            reps = $urandom_range(2, 1);
            if (reps * rows * cols > left) reps = 1;
            case ($urandom_range(3))
                0: begin
                    ra = CFG_W'($urandom_range(rows + 1));
                    rb = ra;
                    ca = CFG_W'($urandom_range(cols + 1));
                    cb = CFG_W'($urandom_range(cols + 1));
                end
                1: begin
                    ca = CFG_W'($urandom_range(cols));
                    cb = ca;
                    ra = CFG_W'($urandom_range(rows + 1));
                    rb = CFG_W'($urandom_range(rows + 1));
                end
                2: begin
                    ra = CFG_W'($urandom_range(rows + 1));
                    rb = CFG_W'($urandom_range(rows + 1));
                    ca = CFG_W'($urandom_range(cols + 1));
                    cb = CFG_W'($urandom_range(cols + 1));
                end
                default: begin
                    ra = CFG_W'($urandom_range(2047));
                    rb = CFG_W'($urandom_range(2047));
                    ca = CFG_W'($urandom_range(2047));
                    cb = CFG_W'($urandom_range(2047));
                end
            endcase
            // registers change only with nothing in flight
            wait_results_in();
            set_size((rows == 1 && $urandom_range(1)) ? 11'd0 : CFG_W'(rows),
                     (cols == 1 && $urandom_range(1)) ? 11'd0 : CFG_W'(cols));
            set_wall(ra, ca, rb, cb);
            repeat (reps) send_grid(rows * cols);
        end
        wait_results_in();
    endtask

    // reset, stimulus, final verdict
    initial begin
        cell_if.valid      = 1'b0;
        cell_if.cell_value = '0;
        res_if.ready       = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_values();
        test_wall_shapes();
        test_size_limits();
        test_random_grids(0, 0, 212);
        test_random_grids(84, 0, 212);
        test_random_grids(0, 84, 212);
        test_random_grids(22, 22, 212);

        wait_results_in();
        repeat (8) @(posedge clk);
        $display("sent %0d cells, checked %0d corner results (%0d with the corner cut off)",
                 cells_sent, grids_checked, grids_blocked);
        $display("%0d register writes over walls of every orientation and clamped sizes, %0d errors",
                 reg_writes, error_count);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
